@@ hdl/two_zone_people_counter_top_defines.svh @@
// assertion helpers for the two-zone people counter
`ifndef TWO_ZONE_PEOPLE_COUNTER_TOP_DEFINES_SVH
`define TWO_ZONE_PEOPLE_COUNTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property checked every cycle outside reset
`define TZPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition in one cycle implies a result in the next
`define TZPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TZPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TZPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hdl/tzpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tzpc_pkg;

  // field widths
  localparam int DIST_W  = 16;
  localparam int STAT_W  = 8;
  localparam int LIM_W   = 13;
  localparam int THR_W   = 16;
  localparam int CNT_W   = 16;
  localparam int TOT_W   = 32;
  localparam int EV_W    = 3;
  localparam int OP_W    = 2;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_SAMPLE      = 2'd0;
  localparam logic [OP_W-1:0] OP_CLR_PEOPLE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR_ENTERED = 2'd2;

  // zone event codes
  localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EV_W-1:0] EV_INVALID = 3'd1;
  localparam logic [EV_W-1:0] EV_FILLING = 3'd2;
  localparam logic [EV_W-1:0] EV_ENTER   = 3'd3;
  localparam logic [EV_W-1:0] EV_LEAVE   = 3'd4;

  // range status codes
  localparam logic [STAT_W-1:0] RS_VALID      = 8'd0;
  localparam logic [STAT_W-1:0] RS_SIGMA_FAIL = 8'd1;
  localparam logic [STAT_W-1:0] RS_SIGNAL_FAIL = 8'd2;
  localparam logic [STAT_W-1:0] RS_OUT_BOUNDS = 8'd4;
  localparam logic [STAT_W-1:0] RS_HW_FAIL    = 8'd5;
  localparam logic [STAT_W-1:0] RS_WRAP_CHECK = 8'd7;
  localparam logic [STAT_W-1:0] RS_PROC_FAIL  = 8'd8;
  localparam logic [STAT_W-1:0] RS_ROI_ERROR  = 8'd13;
  localparam logic [STAT_W-1:0] RS_ROI_FAIL   = 8'd14;

  // occupancy patterns, bit 0 front zone, bit 1 back zone
  localparam logic [1:0] PAT_FRONT = 2'd1;
  localparam logic [1:0] PAT_BACK  = 2'd2;
  localparam logic [1:0] PAT_BOTH  = 2'd3;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_NEAR = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FAR  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_THR  = 2'd2;

  // configuration reset values
  localparam logic [LIM_W-1:0] NEAR_RST = 13'd0;
  localparam logic [LIM_W-1:0] FAR_RST  = 13'd4000;
  localparam logic [THR_W-1:0] THR_RST  = 16'd1600;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic write;
    logic scan;
    logic track;
    logic finish;
  } tzpc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_sample;
    logic scan_last;
    logic out_free;
  } tzpc_sts_t;

endpackage

`default_nettype wire

@@ hdl/tzpc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "two_zone_people_counter_top_defines.svh"

module tzpc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  tzpc_pkg::tzpc_sts_t    sts,
  output tzpc_pkg::tzpc_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WRITE = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_TRACK = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.load   = accept;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = sts.in_is_sample ? S_WRITE : S_FIN;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_TRACK;
      end
      S_TRACK: begin
        cmd.track = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TZPC_ASSERT_NEXT(a_sample_to_write, clk, rst_n, accept && sts.in_is_sample, state_r == S_WRITE, "sample did not start window write")
  `TZPC_ASSERT_NEXT(a_clear_to_fin, clk, rst_n, accept && !sts.in_is_sample, state_r == S_FIN, "clear did not go to finish")
  `TZPC_ASSERT_NEXT(a_drain_to_track, clk, rst_n, state_r == S_DRAIN, state_r == S_TRACK, "drain not followed by tracking")
  `TZPC_ASSERT(a_fin_waits, clk, rst_n, (state_r == S_FIN && !sts.out_free) |=> state_r == S_FIN, "finish left while output busy")

endmodule

`default_nettype wire

@@ hdl/tzpc_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "two_zone_people_counter_top_defines.svh"

module tzpc_dp #(
  parameter int WINDOW_DEPTH = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [tzpc_pkg::OP_W-1:0]         in_operation,
  input  wire logic [tzpc_pkg::DIST_W-1:0]       in_distance,
  input  wire logic [tzpc_pkg::STAT_W-1:0]       in_range_status,
  input  wire logic                              cfg_we,
  input  wire logic [tzpc_pkg::CIDX_W-1:0]       cfg_index,
  input  wire logic [tzpc_pkg::CDATA_W-1:0]      cfg_data,
  input  tzpc_pkg::tzpc_cmd_t                    cmd,
  output tzpc_pkg::tzpc_sts_t                    sts,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [tzpc_pkg::CNT_W-1:0]             out_head_count,
  output logic [tzpc_pkg::TOT_W-1:0]             out_entered_total,
  output logic [tzpc_pkg::EV_W-1:0]              out_path_event,
  output logic                                   out_zone_occupied,
  output logic [tzpc_pkg::DIST_W-1:0]            out_corrected_distance,
  output logic                                   out_next_zone,
  output logic                                   out_roi_error
);

  localparam int SW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(2 * WINDOW_DEPTH) : 1;
  localparam int MD = 2 * WINDOW_DEPTH;

  // latched input beat
  logic [tzpc_pkg::OP_W-1:0]   op_r;
  logic [tzpc_pkg::DIST_W-1:0] dist_r;
  logic [tzpc_pkg::STAT_W-1:0] stat_r;

  // configuration
  logic [tzpc_pkg::LIM_W-1:0] near_r;
  logic [tzpc_pkg::LIM_W-1:0] far_r;
  logic [tzpc_pkg::THR_W-1:0] thr_r;

  // window memory and scan
  logic [tzpc_pkg::DIST_W-1:0] mem [MD];
  logic [tzpc_pkg::DIST_W-1:0] rdata_r;
  logic                        rd_vld_r;
  logic                        rd_first_r;
  logic [SW-1:0]               rd_cnt_r;
  logic [tzpc_pkg::DIST_W-1:0] min_r;
  logic [AW-1:0]               base;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;

  // per-zone window control
  logic [SW-1:0] ws_r   [2];
  logic [CW-1:0] fill_r [2];
  logic [SW-1:0] ws_cur;
  logic [CW-1:0] fill_cur;

  // sample results
  logic [tzpc_pkg::DIST_W-1:0] cd_nxt, cd_r;
  logic                        roi_nxt, roi_r;
  logic                        occ_nxt, occ_r;
  logic [tzpc_pkg::EV_W-1:0]   ev_nxt, ev_r;

  // path tracking state
  logic       zone_r;
  logic       left_r, right_r;
  logic [2:0] pf_r;
  logic [1:0] pst_r [4];
  logic       cur_busy, changed, new_left, new_right, judged;
  logic [1:0] pat;
  logic [2:0] pf_inc;
  logic [2:0] pf_idx;

  // counters
  logic [tzpc_pkg::CNT_W-1:0] inside_r;
  logic [tzpc_pkg::TOT_W-1:0] entered_r;
  logic                       out_valid_r;

  assign ws_cur   = ws_r[zone_r];
  assign fill_cur = fill_r[zone_r];
  assign base     = zone_r ? AW'(WINDOW_DEPTH) : '0;
  assign waddr    = base + AW'(ws_cur);
  assign raddr    = base + AW'(rd_cnt_r);

  assign sts.in_is_sample = (in_operation == tzpc_pkg::OP_SAMPLE);
  assign sts.scan_last    = (rd_cnt_r == SW'(fill_cur - CW'(1)));
  assign sts.out_free     = !out_valid_r || !out_stall;

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      dist_r <= in_distance;
      stat_r <= in_range_status;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= tzpc_pkg::NEAR_RST;
      far_r  <= tzpc_pkg::FAR_RST;
      thr_r  <= tzpc_pkg::THR_RST;
    end else if (cfg_we) begin
      if (cfg_index == tzpc_pkg::CFG_NEAR) begin
        near_r <= cfg_data[tzpc_pkg::LIM_W-1:0];
      end
      if (cfg_index == tzpc_pkg::CFG_FAR) begin
        far_r <= cfg_data[tzpc_pkg::LIM_W-1:0];
      end
      if (cfg_index == tzpc_pkg::CFG_THR) begin
        thr_r <= cfg_data;
      end
    end
  end

  // range status correction
  always_comb begin
    cd_nxt  = dist_r;
    roi_nxt = 1'b0;
    unique case (stat_r)
      tzpc_pkg::RS_VALID, tzpc_pkg::RS_OUT_BOUNDS, tzpc_pkg::RS_WRAP_CHECK: begin
        if (dist_r <= {3'b000, near_r}) begin
          cd_nxt = {2'b00, {1'b0, near_r} + {1'b0, far_r}};
        end
      end
      tzpc_pkg::RS_SIGMA_FAIL, tzpc_pkg::RS_SIGNAL_FAIL, tzpc_pkg::RS_HW_FAIL,
      tzpc_pkg::RS_PROC_FAIL, tzpc_pkg::RS_ROI_FAIL: begin
        cd_nxt = {3'b000, far_r};
      end
      tzpc_pkg::RS_ROI_ERROR: begin
        roi_nxt = 1'b1;
      end
      default: begin
        cd_nxt = dist_r;
      end
    endcase
  end

  // window memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[waddr] <= cd_nxt;
    end
    rdata_r <= mem[raddr];
  end

  // scan pipeline and running minimum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      rd_first_r <= 1'b0;
      rd_cnt_r   <= '0;
    end else begin
      rd_vld_r   <= cmd.scan;
      rd_first_r <= (rd_cnt_r == '0);
      if (cmd.write) begin
        rd_cnt_r <= '0;
      end else if (cmd.scan) begin
        rd_cnt_r <= rd_cnt_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r && (rd_first_r || (rdata_r < min_r))) begin
      min_r <= rdata_r;
    end
  end

  // corrected sample kept for the result
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      cd_r  <= cd_nxt;
      roi_r <= roi_nxt;
    end
  end

  // occupancy and path judgment
  always_comb begin
    occ_nxt   = (min_r < thr_r);
    cur_busy  = zone_r ? right_r : left_r;
    changed   = (occ_nxt != cur_busy);
    new_left  = zone_r ? left_r : occ_nxt;
    new_right = zone_r ? occ_nxt : right_r;
    pat       = {new_right, new_left};
    pf_inc    = (pf_r < 3'd4) ? pf_r + 3'd1 : pf_r;
    pf_idx    = pf_inc - 3'd1;
    ev_nxt    = tzpc_pkg::EV_NONE;
    if (changed) begin
      if (!new_left && !new_right) begin
        if (pf_inc == 3'd4) begin
          priority if (pst_r[1] == tzpc_pkg::PAT_FRONT && pst_r[2] == tzpc_pkg::PAT_BOTH &&
                       pst_r[3] == tzpc_pkg::PAT_BACK) begin
            ev_nxt = tzpc_pkg::EV_ENTER;
          end else if (pst_r[1] == tzpc_pkg::PAT_BACK && pst_r[2] == tzpc_pkg::PAT_BOTH &&
                       pst_r[3] == tzpc_pkg::PAT_FRONT) begin
            ev_nxt = tzpc_pkg::EV_LEAVE;
          end else begin
            ev_nxt = tzpc_pkg::EV_INVALID;
          end
        end
      end else begin
        ev_nxt = tzpc_pkg::EV_FILLING;
      end
    end
    judged = (ev_nxt == tzpc_pkg::EV_ENTER) || (ev_nxt == tzpc_pkg::EV_LEAVE) ||
             (ev_nxt == tzpc_pkg::EV_INVALID);
  end

  // window pointers, zone and path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r[0]   <= '0;
      ws_r[1]   <= '0;
      fill_r[0] <= '0;
      fill_r[1] <= '0;
      zone_r    <= 1'b0;
      left_r    <= 1'b0;
      right_r   <= 1'b0;
      pf_r      <= '0;
      pst_r[0]  <= '0;
      pst_r[1]  <= '0;
      pst_r[2]  <= '0;
      pst_r[3]  <= '0;
    end else if (cmd.write) begin
      ws_r[zone_r] <= (ws_cur == SW'(WINDOW_DEPTH - 1)) ? '0 : ws_cur + SW'(1);
      if (fill_cur != CW'(WINDOW_DEPTH)) begin
        fill_r[zone_r] <= fill_cur + CW'(1);
      end
    end else if (cmd.track) begin
      zone_r <= ~zone_r;
      if (changed) begin
        left_r  <= new_left;
        right_r <= new_right;
        if (!new_left && !new_right) begin
          pf_r <= 3'd1;
        end else begin
          pst_r[pf_idx[1:0]] <= pat;
          pf_r               <= pf_inc;
        end
      end
      if (judged) begin
        ws_r[0]   <= '0;
        ws_r[1]   <= '0;
        fill_r[0] <= '0;
        fill_r[1] <= '0;
      end
    end
  end

  // event and occupancy of this sample
  always_ff @(posedge clk) begin
    if (cmd.track) begin
      ev_r  <= ev_nxt;
      occ_r <= occ_nxt;
    end
  end

  // people and entered counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r  <= '0;
      entered_r <= '0;
    end else if (cmd.track) begin
      if (ev_nxt == tzpc_pkg::EV_ENTER) begin
        if (inside_r != '1) begin
          inside_r <= inside_r + 16'd1;
        end
        entered_r <= entered_r + 32'd1;
      end else if (ev_nxt == tzpc_pkg::EV_LEAVE) begin
        if (inside_r != '0) begin
          inside_r <= inside_r - 16'd1;
        end
      end
    end else if (cmd.finish) begin
      if (op_r == tzpc_pkg::OP_CLR_PEOPLE) begin
        inside_r <= '0;
      end
      if (op_r == tzpc_pkg::OP_CLR_ENTERED) begin
        entered_r <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_head_count    <= (op_r == tzpc_pkg::OP_CLR_PEOPLE) ? '0 : inside_r;
      out_entered_total <= (op_r == tzpc_pkg::OP_CLR_ENTERED) ? '0 : entered_r;
      out_next_zone     <= zone_r;
      if (op_r == tzpc_pkg::OP_SAMPLE) begin
        out_path_event         <= ev_r;
        out_zone_occupied      <= occ_r;
        out_corrected_distance <= cd_r;
        out_roi_error          <= roi_r;
      end else begin
        out_path_event         <= tzpc_pkg::EV_NONE;
        out_zone_occupied      <= 1'b0;
        out_corrected_distance <= '0;
        out_roi_error          <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  `TZPC_ASSERT(a_fill_bound, clk, rst_n,
    fill_r[0] <= CW'(WINDOW_DEPTH) && fill_r[1] <= CW'(WINDOW_DEPTH), "window fill above depth")
  `TZPC_ASSERT(a_scan_in_fill, clk, rst_n,
    cmd.scan |-> CW'(rd_cnt_r) < fill_cur, "scan beyond written slots")
  `TZPC_ASSERT_NEXT(a_judged_clears, clk, rst_n, cmd.track && judged,
    fill_r[0] == '0 && fill_r[1] == '0, "judged path left window filled")
  `TZPC_ASSERT_NEXT(a_entered_step, clk, rst_n, cmd.track && ev_nxt != tzpc_pkg::EV_ENTER,
    entered_r == $past(entered_r), "entered total moved without enter")

endmodule

`default_nettype wire

@@ hdl/two_zone_people_counter_top.sv @@
// Two-zone people counter.
// Input channel (in_valid / in_stall) carries one beat per ranging result or
// command: in_operation selects a new sample, a people count clear or an
// entered total clear; a sample belongs to the zone given by the previous
// beat's out_next_zone, starting with the front zone after reset.
// Output channel (out_valid / out_stall) returns exactly one beat per input
// beat, in order. The config port (cfg_we, cfg_index, cfg_data) writes
// near_limit, far_limit and presence_threshold; the user must do so only
// while the block is idle, as the block itself does not enforce it.
// A sample with window fill n (1..WINDOW_DEPTH) scans n slots through
// the single read port of the window memory; the next beat is taken only
// after its result has been loaded into the output register. Clear commands
// skip the window and go straight to the result.
// Reset (synchronous, rst_n low) clears counts, path tracking and window
// pointers and loads the config defaults; window contents are not cleared.
// A stalled result is held in the output register; the block still accepts
// and processes the next beat and waits only to hand over its result.
`timescale 1ns / 1ps
`default_nettype none

module two_zone_people_counter_top #(
  parameter int WINDOW_DEPTH = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tzpc_pkg::OP_W-1:0]     in_operation,
  input  wire logic [tzpc_pkg::DIST_W-1:0]   in_distance,
  input  wire logic [tzpc_pkg::STAT_W-1:0]   in_range_status,
  input  wire logic                          cfg_we,
  input  wire logic [tzpc_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [tzpc_pkg::CDATA_W-1:0]  cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tzpc_pkg::CNT_W-1:0]         out_head_count,
  output logic [tzpc_pkg::TOT_W-1:0]         out_entered_total,
  output logic [tzpc_pkg::EV_W-1:0]          out_path_event,
  output logic                               out_zone_occupied,
  output logic [tzpc_pkg::DIST_W-1:0]        out_corrected_distance,
  output logic                               out_next_zone,
  output logic                               out_roi_error
);

  tzpc_pkg::tzpc_cmd_t cmd;
  tzpc_pkg::tzpc_sts_t sts;

  // sequencer
  tzpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // window, tracking and counters
  tzpc_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_operation           (in_operation),
    .in_distance            (in_distance),
    .in_range_status        (in_range_status),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .cmd                    (cmd),
    .sts                    (sts),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_head_count         (out_head_count),
    .out_entered_total      (out_entered_total),
    .out_path_event         (out_path_event),
    .out_zone_occupied      (out_zone_occupied),
    .out_corrected_distance (out_corrected_distance),
    .out_next_zone          (out_next_zone),
    .out_roi_error          (out_roi_error)
  );

endmodule

`default_nettype wire

@@ sim/tzpc_checker.sv @@
`timescale 1ns / 1ps

// watches both channels and the config port, keeps its own copy of the
// counter state and compares every result beat with the oldest prediction
module tzpc_checker #(
  parameter int WINDOW_DEPTH = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [tzpc_pkg::OP_W-1:0]     in_operation,
  input  logic [tzpc_pkg::DIST_W-1:0]   in_distance,
  input  logic [tzpc_pkg::STAT_W-1:0]   in_range_status,
  input  logic                          cfg_we,
  input  logic [tzpc_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [tzpc_pkg::CDATA_W-1:0]  cfg_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [tzpc_pkg::CNT_W-1:0]    out_head_count,
  input  logic [tzpc_pkg::TOT_W-1:0]    out_entered_total,
  input  logic [tzpc_pkg::EV_W-1:0]     out_path_event,
  input  logic                          out_zone_occupied,
  input  logic [tzpc_pkg::DIST_W-1:0]   out_corrected_distance,
  input  logic                          out_next_zone,
  input  logic                          out_roi_error,
  output int                            fail_count,
  output int                            pending
);
  import tzpc_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0]  people;
    logic [TOT_W-1:0]  entered;
    logic [EV_W-1:0]   ev;
    logic              occupied;
    logic [DIST_W-1:0] cdist;
    logic              next_zone;
    logic              roi;
  } tally_t;

  // register copies
  logic [LIM_W-1:0] near_lim;
  logic [LIM_W-1:0] far_lim;
  logic [THR_W-1:0] thr;

  // counter state
  logic [DIST_W-1:0] win [2][WINDOW_DEPTH];
  int                wslot [2];
  int                fill [2];
  logic              zone;
  logic              front_busy;
  logic              back_busy;
  int                pfill;
  logic [1:0]        pstore [4];
  logic [CNT_W-1:0]  occupants;
  logic [TOT_W-1:0]  entered;

  tally_t awaited_tallies [$];
  int     flaws = 0;

  function automatic void clear_state();
    near_lim   = NEAR_RST;
    far_lim    = FAR_RST;
    thr        = THR_RST;
    wslot      = '{0, 0};
    fill       = '{0, 0};
    zone       = 1'b0;
    front_busy = 1'b0;
    back_busy  = 1'b0;
    pfill      = 0;
    pstore     = '{2'd0, 2'd0, 2'd0, 2'd0};
    occupants  = '0;
    entered    = '0;
  endfunction

  // occupancy change of one zone feeds the path and may close it
  function automatic logic [EV_W-1:0] path_event(logic busy, logic z);
    logic [1:0]      pat;
    logic [EV_W-1:0] ev;
    if (z == 1'b0) begin
      if (busy == front_busy) return EV_NONE;
      pat = {back_busy, busy};
      front_busy = busy;
    end else begin
      if (busy == back_busy) return EV_NONE;
      pat = {busy, front_busy};
      back_busy = busy;
    end
    if (pfill < 4) pfill++;
    if (!front_busy && !back_busy) begin
      ev = EV_NONE;
      if (pfill == 4) begin
        if (pstore[1] == PAT_FRONT && pstore[2] == PAT_BOTH && pstore[3] == PAT_BACK)
          ev = EV_ENTER;
        else if (pstore[1] == PAT_BACK && pstore[2] == PAT_BOTH && pstore[3] == PAT_FRONT)
          ev = EV_LEAVE;
        else
          ev = EV_INVALID;
      end
      pfill = 1;
    end else begin
      pstore[(pfill - 1) & 3] = pat;
      ev = EV_FILLING;
    end
    return ev;
  endfunction

  // next counter state and the result beat for one input beat
  function automatic tally_t next_tally(logic [OP_W-1:0] op, logic [DIST_W-1:0] mm,
                                        logic [STAT_W-1:0] st);
    tally_t            r;
    logic [LIM_W+3:0]  wrapped;
    logic [DIST_W-1:0] lowest;
    logic              z;
    int                i;
    r = '0;
    if (op == OP_SAMPLE) begin
      z = zone;
      r.cdist = mm;
      wrapped = near_lim + far_lim;
      // range status correction
      case (st)
        RS_VALID, RS_OUT_BOUNDS, RS_WRAP_CHECK: begin
          if (mm <= near_lim) r.cdist = wrapped[DIST_W-1:0];
        end
        RS_SIGMA_FAIL, RS_SIGNAL_FAIL, RS_HW_FAIL, RS_PROC_FAIL, RS_ROI_FAIL: begin
          r.cdist = DIST_W'(far_lim);
        end
        RS_ROI_ERROR: begin
          r.roi = 1'b1;
        end
        default: begin
        end
      endcase
      // window write and minimum over the filled slots
      if (wslot[z] >= WINDOW_DEPTH) wslot[z] = 0;
      win[z][wslot[z]] = r.cdist;
      wslot[z] = (wslot[z] + 1) % WINDOW_DEPTH;
      if (fill[z] < WINDOW_DEPTH) fill[z]++;
      lowest = win[z][0];
      for (i = 1; i < fill[z]; i++)
        if (win[z][i] < lowest) lowest = win[z][i];
      r.occupied = (lowest < thr);
      r.ev = path_event(r.occupied, z);
      if (r.ev == EV_ENTER) begin
        if (occupants != '1) occupants++;
        entered++;
      end else if (r.ev == EV_LEAVE) begin
        if (occupants != '0) occupants--;
      end
      if (r.ev == EV_ENTER || r.ev == EV_LEAVE || r.ev == EV_INVALID) begin
        wslot = '{0, 0};
        fill  = '{0, 0};
      end
      zone = ~z;
    end else if (op == OP_CLR_PEOPLE) begin
      occupants = '0;
    end else if (op == OP_CLR_ENTERED) begin
      entered = '0;
    end
    r.people    = occupants;
    r.entered   = entered;
    r.next_zone = zone;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      flaws++;
    end
  endtask

  // watch config writes, result beats and input beats
  always @(posedge clk) begin : watch
    tally_t want;
    if (!rst_n) begin
      clear_state();
      awaited_tallies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NEAR: near_lim = cfg_data[LIM_W-1:0];
          CFG_FAR:  far_lim  = cfg_data[LIM_W-1:0];
          CFG_THR:  thr      = cfg_data[THR_W-1:0];
          default: begin
          end
        endcase
      end
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (awaited_tallies.size() == 0) begin
          $error("result beat with no prediction waiting");
          flaws++;
        end else begin
          want = awaited_tallies.pop_front();
          check_field("head_count", want.people, out_head_count);
          check_field("entered_total", want.entered, out_entered_total);
          check_field("path_event", want.ev, out_path_event);
          check_field("zone_occupied", want.occupied, out_zone_occupied);
          check_field("corrected_distance", want.cdist, out_corrected_distance);
          check_field("next_zone", want.next_zone, out_next_zone);
          check_field("roi_error", want.roi, out_roi_error);
        end
      end
      if (in_valid && !in_stall)
        awaited_tallies.push_back(next_tally(in_operation, in_distance, in_range_status));
    end
    pending    <= awaited_tallies.size();
    fail_count <= flaws;
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import tzpc_pkg::*;

  localparam int WINDOW_DEPTH = 10;
  localparam int PHASES       = 8;
  localparam int PHASE_BEATS  = 76;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 5000;

  localparam logic [OP_W-1:0]   OP_UNUSED      = 2'd3;
  localparam logic [1:0]        PAT_NONE       = 2'd0;
  localparam logic [STAT_W-1:0] RS_FIRST_PLAIN = 8'd15;

  // idle modes
  localparam int IDLE_NONE = 0;
  localparam int IDLE_TX   = 1;
  localparam int IDLE_RX   = 2;
  localparam int IDLE_BOTH = 3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation = OP_SAMPLE;
  logic [DIST_W-1:0]   in_distance = '0;
  logic [STAT_W-1:0]   in_range_status = RS_VALID;
  logic                cfg_we = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = CFG_NEAR;
  logic [CDATA_W-1:0]  cfg_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CNT_W-1:0]    out_head_count;
  logic [TOT_W-1:0]    out_entered_total;
  logic [EV_W-1:0]     out_path_event;
  logic                out_zone_occupied;
  logic [DIST_W-1:0]   out_corrected_distance;
  logic                out_next_zone;
  logic                out_roi_error;

  int fail_count;
  int pending;

  // stimulus side state
  int               idle_mode = IDLE_NONE;
  logic             hold_req = 1'b0;
  logic             hold_used = 1'b0;
  int               hold_left = 0;
  int               quiet = 0;
  int               beats_sent = 0;
  logic             zone_sel = 1'b0;
  logic [LIM_W-1:0] cur_near = NEAR_RST;
  logic [LIM_W-1:0] cur_far = FAR_RST;
  logic [THR_W-1:0] cur_thr = THR_RST;

  always #5 clk = ~clk;

  two_zone_people_counter_top #(.WINDOW_DEPTH(WINDOW_DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_distance(in_distance),
    .in_range_status(in_range_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_head_count(out_head_count), .out_entered_total(out_entered_total),
    .out_path_event(out_path_event), .out_zone_occupied(out_zone_occupied),
    .out_corrected_distance(out_corrected_distance), .out_next_zone(out_next_zone),
    .out_roi_error(out_roi_error)
  );

  tzpc_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_distance(in_distance),
    .in_range_status(in_range_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_head_count(out_head_count), .out_entered_total(out_entered_total),
    .out_path_event(out_path_event), .out_zone_occupied(out_zone_occupied),
    .out_corrected_distance(out_corrected_distance), .out_next_zone(out_next_zone),
    .out_roi_error(out_roi_error),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stalls per idle mode, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_used) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (idle_mode == IDLE_RX) begin
      out_stall <= ($urandom_range(99, 0) < 53);
    end else if (idle_mode == IDLE_BOTH) begin
      out_stall <= ($urandom_range(99, 0) < 37);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic tx_idles();
    if (idle_mode == IDLE_TX) return ($urandom_range(99, 0) < 53);
    if (idle_mode == IDLE_BOTH) return ($urandom_range(99, 0) < 37);
    return 1'b0;
  endfunction

  // offer one beat and hold it until accepted
  task automatic send_beat(logic [OP_W-1:0] op, logic [DIST_W-1:0] mm,
                           logic [STAT_W-1:0] st);
    while (tx_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_distance     <= mm;
    in_range_status <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_SAMPLE) zone_sel = ~zone_sel;
    beats_sent++;
  endtask

  // stop sending and wait for every predicted result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // register settings per phase, extremes included
  task automatic apply_setting(int phase);
    case (phase)
      0: begin cur_near = NEAR_RST; cur_far = FAR_RST; cur_thr = THR_RST; end
      1: begin cur_near = '1; cur_far = '0; cur_thr = 16'd1600; end
      2: begin cur_near = '0; cur_far = '1; cur_thr = '1; end
      3: begin cur_near = 13'd300; cur_far = 13'd4000; cur_thr = '0; end
      4: begin cur_near = '1; cur_far = '1; cur_thr = 16'd2000; end
      5: begin cur_near = 13'd150; cur_far = 13'd3000; cur_thr = 16'd1000; end
      6: begin
        cur_near = LIM_W'($urandom_range(1000, 0));
        cur_far  = LIM_W'($urandom);
        cur_thr  = THR_W'($urandom_range(4000, 500));
      end
      default: begin cur_near = '0; cur_far = '0; cur_thr = 16'd800; end
    endcase
    write_reg(CFG_NEAR, CDATA_W'(cur_near));
    write_reg(CFG_FAR, CDATA_W'(cur_far));
    write_reg(CFG_THR, CDATA_W'(cur_thr));
    cfg_we <= 1'b0;
  endtask

  // sample that makes the selected zone read near or far
  task automatic send_zone_sample(logic hot);
    logic [DIST_W-1:0] mm;
    logic [STAT_W-1:0] st;
    if (hot)
      mm = (cur_thr == 0) ? DIST_W'($urandom)
                          : DIST_W'($urandom_range(int'(cur_thr) - 1, 0));
    else
      mm = DIST_W'($urandom_range(16'hFFFF, cur_thr));
    case ($urandom_range(3, 0))
      0: st = RS_VALID;
      1: st = RS_WRAP_CHECK;
      2: st = RS_ROI_ERROR;
      default: st = STAT_W'($urandom_range(8'hFF, RS_FIRST_PLAIN));
    endcase
    if ((st == RS_VALID || st == RS_WRAP_CHECK) && mm <= cur_near) st = RS_ROI_ERROR;
    if (!hot && cur_far >= cur_thr && $urandom_range(3, 0) == 0) st = RS_SIGNAL_FAIL;
    send_beat(OP_SAMPLE, mm, st);
  endtask

  // person crossing: enter, leave, or a broken path ending empty
  task automatic run_walk(int kind);
    logic [1:0] plan [4];
    int         len [4];
    int         p;
    int         n;
    logic       hot;
    if (kind == 0) plan = '{PAT_FRONT, PAT_BOTH, PAT_BACK, PAT_NONE};
    else if (kind == 1) plan = '{PAT_BACK, PAT_BOTH, PAT_FRONT, PAT_NONE};
    else plan = '{2'($urandom), 2'($urandom), 2'($urandom), PAT_NONE};
    if (kind < 2)
      len = '{$urandom_range(6, 2), $urandom_range(6, 2), $urandom_range(24, 20),
              $urandom_range(24, 20)};
    else
      len = '{$urandom_range(24, 1), $urandom_range(24, 1), $urandom_range(24, 1), 22};
    for (p = 0; p < 4; p++) begin
      for (n = 0; n < len[p]; n++) begin
        // occasional command in the middle of a crossing
        if ($urandom_range(99, 0) < 4)
          send_beat(OP_W'($urandom_range(OP_UNUSED, OP_CLR_PEOPLE)), DIST_W'($urandom),
                    STAT_W'($urandom));
        hot = zone_sel ? plan[p][1] : plan[p][0];
        send_zone_sample(hot);
      end
    end
  endtask

  // short burst of unstructured beats
  task automatic send_noise();
    int                n;
    int                k;
    logic [OP_W-1:0]   op;
    logic [DIST_W-1:0] mm;
    logic [STAT_W-1:0] st;
    n = $urandom_range(8, 1);
    for (k = 0; k < n; k++) begin
      op = ($urandom_range(99, 0) < 85) ? OP_SAMPLE : OP_W'($urandom_range(OP_UNUSED, 1));
      case ($urandom_range(5, 0))
        0: mm = '0;
        1: mm = '1;
        2: mm = DIST_W'(cur_near);
        3: mm = DIST_W'(cur_near) + DIST_W'(1);
        default: mm = DIST_W'($urandom);
      endcase
      st = $urandom_range(1, 0) ? STAT_W'($urandom_range(RS_FIRST_PLAIN, 0))
                                : STAT_W'($urandom);
      send_beat(op, mm, st);
    end
  endtask

  // directed part: every status class at both distance extremes, all commands
  task automatic run_directed();
    logic [STAT_W-1:0] codes [10];
    int                k;
    codes = '{RS_VALID, RS_SIGMA_FAIL, RS_SIGNAL_FAIL, RS_OUT_BOUNDS, RS_HW_FAIL,
              RS_WRAP_CHECK, RS_PROC_FAIL, RS_ROI_ERROR, RS_ROI_FAIL, '1};
    for (k = 0; k < 10; k++) begin
      send_beat(OP_SAMPLE, '0, codes[k]);
      send_beat(OP_SAMPLE, '1, codes[k]);
    end
    send_beat(OP_CLR_PEOPLE, '1, '1);
    send_beat(OP_CLR_ENTERED, '1, '1);
    send_beat(OP_UNUSED, '1, '1);
  endtask

  initial begin
    int phase;
    int start;
    int pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      apply_setting(phase);
      idle_mode <= phase % 4;
      if (phase == 2) hold_req <= 1'b1;
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) begin
        pick = $urandom_range(99, 0);
        if (pick < 35) run_walk(0);
        else if (pick < 70) run_walk(1);
        else if (pick < 85) run_walk(2);
        else send_noise();
      end
    end
    settle();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
